[rtl/csc_pkg.sv]
// shared types, widths and constants of the cordic sine/cosine pipeline
package csc_pkg;

  localparam int ANGLE_W     = 20;
  localparam int OUT_W       = 18;
  // residual angle: input range plus the sum of all arctangents
  localparam int Z_W         = 22;
  // vector in q.30, magnitude stays below 2^31, two guard bits
  localparam int VEC_W       = 34;
  localparam int VEC_FRAC    = 30;
  localparam int MAG_W       = 32;
  localparam int GAIN_W      = 32;
  localparam int PROD_W      = MAG_W + GAIN_W;
  // q.62 product down to q.16
  localparam int ROUND_SHIFT = VEC_FRAC + GAIN_W - 16;
  localparam int Q_W         = PROD_W + 1 - ROUND_SHIFT;
  localparam int TABLE_LEN   = 32;
  localparam int ATAN_W      = 17;

  localparam logic [GAIN_W-1:0] GAIN_Q32 = 32'd2608131496;

  localparam logic signed [VEC_W-1:0] X_INIT = VEC_W'(1) << VEC_FRAC;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // atan(2^-i) rounded to q1.16
  localparam logic [ATAN_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2,
    17'd1,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0,
    17'd0,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0
  };

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [Z_W-1:0]   z;
  } vec_t;

endpackage

[rtl/csc_if.sv]
// angle and result channel interfaces
interface csc_angle_if;
  logic                                valid;
  logic                                ready;
  logic signed [csc_pkg::ANGLE_W-1:0]  angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface csc_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [csc_pkg::OUT_W-1:0]  cosine;
  logic signed [csc_pkg::OUT_W-1:0]  sine;

  modport source (output valid, output cosine, output sine, input ready);
  modport sink   (input valid, input cosine, input sine, output ready);
endinterface

[rtl/cordic_sine_cosine.sv]
// cordic sine/cosine generator, top level
// an angle item passes through the iteration stages and then the gain stages to become a result item
// throughput: one item per cycle while not stalled, one pipeline stage per iteration plus three for the gain
// the whole pipeline advances while the output register is empty or being taken
// reset (synchronous, active low) clears all stage valid bits, no data is reset
module cordic_sine_cosine #(
  parameter int unsigned ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  csc_angle_if.sink          in_ch,
  csc_result_if.source       out_ch
);

  logic                en;
  logic [ITERATIONS:0] pipe_vld;
  csc_pkg::vec_t       pipe_vec [ITERATIONS+1];

  assign en           = out_ch.ready || !out_ch.valid;
  assign in_ch.ready  = en;

  assign pipe_vld[0]   = in_ch.valid;
  assign pipe_vec[0].x = csc_pkg::X_INIT;
  assign pipe_vec[0].y = '0;
  assign pipe_vec[0].z = {{(csc_pkg::Z_W - csc_pkg::ANGLE_W){in_ch.angle[csc_pkg::ANGLE_W-1]}},
                          in_ch.angle};

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    csc_stage #(
      .IDX (i)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (pipe_vld[i]),
      .in_vec  (pipe_vec[i]),
      .out_vld (pipe_vld[i+1]),
      .out_vec (pipe_vec[i+1])
    );
  end

  csc_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (pipe_vld[ITERATIONS]),
    .in_vec  (pipe_vec[ITERATIONS]),
    .out_vld (out_ch.valid),
    .out_cos (out_ch.cosine),
    .out_sin (out_ch.sine)
  );

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (pipe_vld[ITERATIONS:1] == '0) && !out_ch.valid)
    else $error("pipeline valid bits not cleared by reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> pipe_vld[1])
    else $error("accepted item missing from first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(pipe_vld[ITERATIONS:1]))
    else $error("stage valid bits moved during stall");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled while output register is empty");

endmodule

[rtl/csc_stage.sv]
// one registered cordic rotation iteration
module csc_stage #(
  parameter int unsigned IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  csc_pkg::vec_t in_vec,
  output logic          out_vld,
  output csc_pkg::vec_t out_vec
);

  logic signed [csc_pkg::Z_W-1:0]   atan_s;
  logic signed [csc_pkg::VEC_W-1:0] xs;
  logic signed [csc_pkg::VEC_W-1:0] ys;
  csc_pkg::vec_t                    vec_nxt;
  csc_pkg::vec_t                    vec_r;
  logic                             vld_r;

  assign atan_s = {{(csc_pkg::Z_W - csc_pkg::ATAN_W){1'b0}}, csc_pkg::ATAN_Q16[IDX]};
  assign xs     = $signed(in_vec.x) >>> IDX;
  assign ys     = $signed(in_vec.y) >>> IDX;

  // negative residual rotates clockwise, zero counts as positive
  always_comb begin
    if (in_vec.z[csc_pkg::Z_W-1]) begin
      vec_nxt.z = in_vec.z + atan_s;
      vec_nxt.x = in_vec.x + ys;
      vec_nxt.y = in_vec.y - xs;
    end else begin
      vec_nxt.z = in_vec.z - atan_s;
      vec_nxt.x = in_vec.x - ys;
      vec_nxt.y = in_vec.y + xs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_vec = vec_r;

endmodule

[rtl/csc_scale.sv]
// gain correction: magnitude, multiply, round and saturate over three stages
module csc_scale (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_vld,
  input  csc_pkg::vec_t                    in_vec,
  output logic                             out_vld,
  output logic signed [csc_pkg::OUT_W-1:0] out_cos,
  output logic signed [csc_pkg::OUT_W-1:0] out_sin
);

  function automatic logic signed [csc_pkg::OUT_W-1:0] round_sat(
    input logic                      neg,
    input logic [csc_pkg::PROD_W-1:0] prod
  );
    logic [csc_pkg::PROD_W:0]  rnd;
    logic [csc_pkg::Q_W-1:0]   q;
    logic signed [csc_pkg::Q_W:0] qs;
    logic signed [csc_pkg::OUT_W-1:0] res;
    rnd = {1'b0, prod} + ((csc_pkg::PROD_W+1)'(1) << (csc_pkg::ROUND_SHIFT - 1));
    q   = rnd[csc_pkg::PROD_W:csc_pkg::ROUND_SHIFT];
    qs  = $signed({1'b0, q});
    if (neg) begin
      if (qs > -(csc_pkg::Q_W+1)'(csc_pkg::OUT_MIN)) begin
        res = csc_pkg::OUT_MIN;
      end else begin
        res = csc_pkg::OUT_W'(-qs);
      end
    end else begin
      if (qs > (csc_pkg::Q_W+1)'(csc_pkg::OUT_MAX)) begin
        res = csc_pkg::OUT_MAX;
      end else begin
        res = csc_pkg::OUT_W'(qs);
      end
    end
    return res;
  endfunction

  logic [csc_pkg::VEC_W-1:0]  x_abs;
  logic [csc_pkg::VEC_W-1:0]  y_abs;

  logic                       s1_vld_r;
  logic                       s1_xneg_r;
  logic                       s1_yneg_r;
  logic [csc_pkg::MAG_W-1:0]  s1_xmag_r;
  logic [csc_pkg::MAG_W-1:0]  s1_ymag_r;

  logic                       s2_vld_r;
  logic                       s2_xneg_r;
  logic                       s2_yneg_r;
  logic [csc_pkg::PROD_W-1:0] s2_xprod_r;
  logic [csc_pkg::PROD_W-1:0] s2_yprod_r;

  logic                       out_vld_r;
  logic signed [csc_pkg::OUT_W-1:0] cos_r;
  logic signed [csc_pkg::OUT_W-1:0] sin_r;

  assign x_abs = in_vec.x[csc_pkg::VEC_W-1] ? -in_vec.x : in_vec.x;
  assign y_abs = in_vec.y[csc_pkg::VEC_W-1] ? -in_vec.y : in_vec.y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r  <= in_vld;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_xneg_r  <= in_vec.x[csc_pkg::VEC_W-1];
      s1_yneg_r  <= in_vec.y[csc_pkg::VEC_W-1];
      // magnitude stays below 2^31
      s1_xmag_r  <= x_abs[csc_pkg::MAG_W-1:0];
      s1_ymag_r  <= y_abs[csc_pkg::MAG_W-1:0];
      s2_xneg_r  <= s1_xneg_r;
      s2_yneg_r  <= s1_yneg_r;
      s2_xprod_r <= s1_xmag_r * csc_pkg::GAIN_Q32;
      s2_yprod_r <= s1_ymag_r * csc_pkg::GAIN_Q32;
      cos_r      <= round_sat(s2_xneg_r, s2_xprod_r);
      sin_r      <= round_sat(s2_yneg_r, s2_yprod_r);
    end
  end

  assign out_vld = out_vld_r;
  assign out_cos = cos_r;
  assign out_sin = sin_r;

endmodule

[dv/tb_top.sv]
// cordic sine/cosine testbench: directed and random angles checked against a bit-exact model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITERS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM = 1880;
  localparam int CALM_TAIL = 150;

  typedef struct {
    logic signed [csc_pkg::ANGLE_W-1:0] angle;
    bit                                 drain;
  } angle_item_t;

  typedef struct packed {
    logic signed [csc_pkg::OUT_W-1:0] cosine;
    logic signed [csc_pkg::OUT_W-1:0] sine;
  } trig_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  csc_angle_if  angle_ch ();
  csc_result_if result_ch ();

  cordic_sine_cosine #(
    .ITERATIONS(ITERS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (angle_ch),
    .out_ch(result_ch)
  );

  angle_item_t angles_pending [$];
  trig_t       sincos_due [$];
  int          err_count = 0;
  int          cycles = 0;
  int          send_gap = 0;
  int          stall_left = 0;
  bit          calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // vector scaled by the gain, q.62 rounded to q.16 with ties away from zero, then saturated
  function automatic logic signed [csc_pkg::OUT_W-1:0] gain_round(input longint v);
    logic [63:0] mag;
    logic [63:0] q;
    longint      r;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    q = (mag * 64'd2608131496 + (64'd1 << 45)) >> 46;
    if (q > (64'd1 << 20)) q = 64'd1 << 20;
    r = (v < 0) ? -longint'(q) : longint'(q);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[csc_pkg::OUT_W-1:0];
  endfunction

  function automatic trig_t cordic_predict(input logic signed [csc_pkg::ANGLE_W-1:0] angle);
    longint resid;
    longint x;
    longint y;
    longint nx;
    longint ny;
    longint step;
    trig_t  res;
    resid = angle;
    x = longint'(1) <<< 30;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      case (i)
        0:  step = 51472;
        1:  step = 30386;
        2:  step = 16055;
        3:  step = 8150;
        4:  step = 4091;
        5:  step = 2047;
        6:  step = 1024;
        7:  step = 512;
        8:  step = 256;
        9:  step = 128;
        10: step = 64;
        11: step = 32;
        12: step = 16;
        13: step = 8;
        14: step = 4;
        15: step = 2;
        16: step = 1;
        default: step = 0;
      endcase
      // zero residual rotates as if positive
      if (resid < 0) begin
        resid = resid + step;
        nx = x + (y >>> i);
        ny = y - (x >>> i);
      end else begin
        resid = resid - step;
        nx = x - (y >>> i);
        ny = y + (x >>> i);
      end
      x = nx;
      y = ny;
    end
    res.cosine = gain_round(x);
    res.sine = gain_round(y);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic signed [csc_pkg::ANGLE_W-1:0] random_angle();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      return csc_pkg::ANGLE_W'($urandom_range(0, (1 << csc_pkg::ANGLE_W) - 1));
    end
    // inside the convergence range
    if (pick < 8) return csc_pkg::ANGLE_W'(int'($urandom_range(0, 228000)) - 114000);
    if (pick == 8) return csc_pkg::ANGLE_W'(int'($urandom_range(0, 128)) - 64);
    return ($urandom_range(0, 1) == 1) ?
           csc_pkg::ANGLE_W'(524287 - int'($urandom_range(0, 63))) :
           csc_pkg::ANGLE_W'(-524288 + int'($urandom_range(0, 63)));
  endfunction

  assign calm = (angles_pending.size() < CALM_TAIL);

  // angle driver
  always @(posedge clk) begin
    angle_item_t itm;
    bit          free;
    if (!rst_n) begin
      angle_ch.valid <= 1'b0;
      angle_ch.angle <= '0;
      send_gap = 0;
    end else begin
      free = !angle_ch.valid;
      if (angle_ch.valid && angle_ch.ready) begin
        sincos_due.push_back(cordic_predict(angle_ch.angle));
        free = 1'b1;
      end
      if (free) begin
        if (send_gap > 0) begin
          send_gap--;
          angle_ch.valid <= 1'b0;
        end else if (angles_pending.size() == 0 ||
                     (angles_pending[0].drain && sincos_due.size() != 0)) begin
          angle_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 9);
          angle_ch.valid <= 1'b0;
        end else begin
          itm = angles_pending.pop_front();
          angle_ch.valid <= 1'b1;
          angle_ch.angle <= itm.angle;
        end
      end
    end
  end

  // result sink with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      result_ch.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 9);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    trig_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (sincos_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result cos=%0d sin=%0d",
                                  result_ch.cosine, result_ch.sine));
      end else begin
        want = sincos_due.pop_front();
        if (result_ch.cosine !== want.cosine)
          report_mismatch($sformatf("cosine got %0d want %0d", result_ch.cosine, want.cosine));
        if (result_ch.sine !== want.sine)
          report_mismatch($sformatf("sine got %0d want %0d", result_ch.sine, want.sine));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [csc_pkg::ANGLE_W-1:0] directed [$];
    angle_item_t itm;

    // extremes, quadrant edges and residuals that hit zero mid-rotation
    directed = '{20'sd0, 20'sd1, -20'sd1, 20'sd524287, -20'sd524288,
                 20'sd51472, -20'sd51472, 20'sd81858, -20'sd81858,
                 20'sd102944, -20'sd102944, 20'sd114032, -20'sd114032,
                 20'sd114100, -20'sd114100, 20'sd205887, -20'sd205887,
                 20'sd411775, -20'sd411775, 20'sd34317, -20'sd17158,
                 20'sd262144, -20'sd262144};
    foreach (directed[k]) begin
      itm.angle = directed[k];
      itm.drain = 1'b0;
      angles_pending.push_back(itm);
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      itm.angle = random_angle();
      // let the pipeline run empty before the random part and once mid-run
      itm.drain = (k == 0 || k == N_RANDOM / 2);
      angles_pending.push_back(itm);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (angles_pending.size() != 0 || angle_ch.valid) @(posedge clk);
    while (sincos_due.size() != 0) @(posedge clk);
    repeat (ITERS + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
